>>> hdl/pgdu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgdu_pkg
// Shared types and constants of the plane-guided depth upsampler.
// ----------------------------------------------------------------------------
package pgdu_pkg;

  localparam int CFG_W    = 24;
  localparam int FACT_W   = 4;
  localparam int COORD_W  = 12;
  localparam int DEPTH_W  = 32;
  localparam int NORM_W   = 16;
  localparam int OCOORD_W = 15;
  localparam int PLANE_W  = 72;   // signed plane / ray terms
  localparam int UV_W     = 41;   // normal component times focal length
  localparam int NUM_W    = 104;  // depth times plane term
  localparam int IN_W     = 104;
  localparam int OUT_W    = 64;
  localparam int ADDR_W   = 3;
  localparam int QDEPTH   = 2;

  localparam logic [ADDR_W-1:0] REG_FOCAL_X = 3'd0;
  localparam logic [ADDR_W-1:0] REG_FOCAL_Y = 3'd1;
  localparam logic [ADDR_W-1:0] REG_CENTER_X = 3'd2;
  localparam logic [ADDR_W-1:0] REG_CENTER_Y = 3'd3;
  localparam logic [ADDR_W-1:0] REG_FACTOR  = 3'd4;

  // effective configuration: focal lengths never zero, factor clamped
  typedef struct packed {
    logic [CFG_W-1:0]  fx;
    logic [CFG_W-1:0]  fy;
    logic [CFG_W-1:0]  cx;
    logic [CFG_W-1:0]  cy;
    logic [FACT_W-1:0] f;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0]        c;
    logic [COORD_W-1:0]        r;
    logic [DEPTH_W-1:0]        d;
    logic signed [PLANE_W-1:0] nm;
    logic signed [UV_W-1:0]    u;
    logic signed [UV_W-1:0]    v;
  } item_t;

  typedef struct packed {
    logic [1:0] count;
    logic       full;
    logic       empty;
  } qstat_t;

endpackage

>>> hdl/plane_guided_depth_upsampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plane_guided_depth_upsampler
// Upsamples a depth pixel into F x F sub-pixel depths on its tangent plane.
// ----------------------------------------------------------------------------
// channel | dir | payload
// s_*     | in  | tdata: pixel_col, pixel_row, depth_in, normal_x/y/z
// m_*     | out | tdata: out_col, out_row, depth_out; tuser: invalid; tlast
// cfg_*   | in  | register writes, index 0..4
//
// Plane term: front pipeline, one pixel per cycle into a 2-word queue while it is not full.
// Back: per pixel, depth times plane in 24-bit chunks; then per sub-pixel the ray
// term and a check, then either the output directly (invalid, zero or saturated
// depth) or a 32-step restoring divider (one bit per cycle) before the output.
// The back pops the next pixel only after the last sub-pixel of the current one.
// Reset is synchronous; registers return to focal 512.0, center 256.0, F=2.
// Back stalls only on m_tready; the front stalls only when the queue is full.
module plane_guided_depth_upsampler #(
  parameter int COL_LIMIT  = 4096,
  parameter int ROW_LIMIT  = 4096,
  parameter int MAX_FACTOR = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // pixel_col, pixel_row, depth_in, normal_x, normal_y, normal_z
  input  logic [pgdu_pkg::IN_W-1:0]     s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // out_col, out_row, depth_out, zero pad
  output logic [pgdu_pkg::OUT_W-1:0]    m_tdata,
  // invalid
  output logic                          m_tuser,
  output logic                          m_tlast,
  input  logic                          cfg_we,
  input  logic [pgdu_pkg::ADDR_W-1:0]   cfg_addr,
  input  logic [pgdu_pkg::CFG_W-1:0]    cfg_data
);
  import pgdu_pkg::*;

  logic [CFG_W-1:0] focal_x, focal_y, center_x, center_y;
  logic [FACT_W-1:0] upscale_factor, f_eff;
  cfg_t cfg;
  logic push, push_ready, q_valid, q_pop;
  item_t push_item, q_item;
  qstat_t qstat;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x <= 24'd131072; focal_y <= 24'd131072;
      center_x <= 24'd65536; center_y <= 24'd65536;
      upscale_factor <= 4'd2;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FOCAL_X:  focal_x <= cfg_data;
        REG_FOCAL_Y:  focal_y <= cfg_data;
        REG_CENTER_X: center_x <= cfg_data;
        REG_CENTER_Y: center_y <= cfg_data;
        REG_FACTOR:   upscale_factor <= cfg_data[FACT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    f_eff = upscale_factor;
    if (upscale_factor == '0) f_eff = 4'd1;
    else if (int'(upscale_factor) > MAX_FACTOR) f_eff = FACT_W'(MAX_FACTOR);
  end

  assign cfg = '{fx: (focal_x == '0) ? 24'd1 : focal_x,
                 fy: (focal_y == '0) ? 24'd1 : focal_y,
                 cx: center_x, cy: center_y, f: f_eff};

  pgdu_front #(.COL_LIMIT(COL_LIMIT), .ROW_LIMIT(ROW_LIMIT)) u_front (
    .clk, .rst, .cfg,
    .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
    .push, .push_item, .push_ready
  );

  pgdu_queue u_queue (
    .clk, .rst, .push, .push_item, .push_ready,
    .pop(q_pop), .pop_item(q_item), .pop_valid(q_valid), .stat(qstat)
  );

  pgdu_back u_back (
    .clk, .rst, .cfg, .q_valid, .q_item, .q_pop,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

  // an invalid ray always carries depth 0
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[61:30] == '0)
    else $error("invalid result with nonzero depth");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= 2'(QDEPTH) && !(qstat.full && qstat.empty))
    else $error("queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    qstat.empty |-> !q_pop)
    else $error("pop from empty queue");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule

>>> hdl/pgdu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgdu_front
// Five-stage pipeline: clamps coordinates and forms the plane term.
// ----------------------------------------------------------------------------
module pgdu_front #(
  parameter int COL_LIMIT = 4096,
  parameter int ROW_LIMIT = 4096
) (
  input  logic                     clk,
  input  logic                     rst,
  input  pgdu_pkg::cfg_t           cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [pgdu_pkg::IN_W-1:0] in_data,
  output logic                     push,
  output pgdu_pkg::item_t          push_item,
  input  logic                     push_ready
);
  import pgdu_pkg::*;

  logic v1, v2, v3, v4, v5, en;
  logic [COORD_W-1:0] c1, r1, c2, r2, c3, r3, c4, r4, c5, r5;
  logic [DEPTH_W-1:0] d1, d2, d3, d4, d5;
  logic signed [NORM_W-1:0] nx1, ny1;
  logic signed [31:0] a1, b1;
  logic signed [21:0] k1;
  logic signed [47:0] p1, p2, p3;
  logic signed [UV_W-1:0] u2, v2u, u3, v3u, u4, v4u, u5, v5u;
  logic signed [49:0] l1, l2, l3;
  logic signed [48:0] h1, h2, h3;
  logic signed [PLANE_W-1:0] t1, t2, t3, nm5;

  logic [COORD_W-1:0] c_in, r_in, c_cl, r_cl;
  logic signed [NORM_W-1:0] nz_in;
  logic signed [25:0] dx, dy;
  logic signed [5:0] f2;
  logic signed [24:0] fx_s, fy_s;

  assign c_in  = in_data[11:0];
  assign r_in  = in_data[23:12];
  assign nz_in = $signed(in_data[103:88]);
  assign c_cl  = (int'(c_in) > COL_LIMIT - 1) ? COORD_W'(COL_LIMIT - 1) : c_in;
  assign r_cl  = (int'(r_in) > ROW_LIMIT - 1) ? COORD_W'(ROW_LIMIT - 1) : r_in;
  assign dx    = $signed({6'b0, c_cl, 8'b0}) - $signed({2'b0, cfg.cx});
  assign dy    = $signed({6'b0, r_cl, 8'b0}) - $signed({2'b0, cfg.cy});
  assign f2    = $signed({1'b0, cfg.f, 1'b0});
  assign fx_s  = $signed({1'b0, cfg.fx});
  assign fy_s  = $signed({1'b0, cfg.fy});

  assign en        = !(v5 && !push_ready);
  assign in_ready  = en;
  assign push      = v5 && push_ready;
  assign push_item = '{c: c5, r: r5, d: d5, nm: nm5, u: u5, v: v5u};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: offsets from the principal point, scaled by 2F
      c1 <= c_cl; r1 <= r_cl; d1 <= in_data[55:24];
      nx1 <= $signed(in_data[71:56]); ny1 <= $signed(in_data[87:72]);
      a1 <= dx * f2;
      b1 <= dy * f2;
      k1 <= nz_in * f2;
      // stage 2
      c2 <= c1; r2 <= r1; d2 <= d1;
      p1 <= a1 * nx1;
      p2 <= b1 * ny1;
      p3 <= k1 * fx_s;
      u2 <= nx1 * fy_s;
      v2u <= ny1 * fx_s;
      // stage 3: second focal factor as two partial products
      c3 <= c2; r3 <= r2; d3 <= d2; u3 <= u2; v3u <= v2u;
      l1 <= $signed({1'b0, p1[23:0]}) * fy_s;
      h1 <= $signed(p1[47:24]) * fy_s;
      l2 <= $signed({1'b0, p2[23:0]}) * fx_s;
      h2 <= $signed(p2[47:24]) * fx_s;
      l3 <= $signed({1'b0, p3[23:0]}) * fy_s;
      h3 <= $signed(p3[47:24]) * fy_s;
      // stage 4
      c4 <= c3; r4 <= r3; d4 <= d3; u4 <= u3; v4u <= v3u;
      t1 <= (h1 <<< 24) + l1;
      t2 <= (h2 <<< 24) + l2;
      t3 <= (h3 <<< 24) + l3;
      // stage 5
      c5 <= c4; r5 <= r4; d5 <= d4; u5 <= u4; v5u <= v4u;
      nm5 <= t1 + t2 + t3;
    end
  end

endmodule

>>> hdl/pgdu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgdu_queue
// Two-entry queue of per-pixel plane words between front and back.
// ----------------------------------------------------------------------------
module pgdu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pgdu_pkg::item_t push_item,
  output logic            push_ready,
  input  logic            pop,
  output pgdu_pkg::item_t pop_item,
  output logic            pop_valid,
  output pgdu_pkg::qstat_t stat
);
  import pgdu_pkg::*;

  item_t mem [QDEPTH];
  logic wp, rp;
  logic [1:0] count;

  assign push_ready = (count != 2'(QDEPTH));
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = mem[rp];
  assign stat       = '{count: count, full: !push_ready, empty: !pop_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; count <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_item;
  end

endmodule

>>> hdl/pgdu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgdu_back
// Walks the sub-pixels of one word, forms each ray term and divides.
// ----------------------------------------------------------------------------
module pgdu_back (
  input  logic                          clk,
  input  logic                          rst,
  input  pgdu_pkg::cfg_t                cfg,
  input  logic                          q_valid,
  input  pgdu_pkg::item_t               q_item,
  output logic                          q_pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [pgdu_pkg::OUT_W-1:0]    m_tdata,
  output logic                          m_tuser,
  output logic                          m_tlast
);
  import pgdu_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_RAY  = 6'b000100,
    ST_CHK  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state;
  item_t cur;
  logic [2:0] i, j;
  logic [1:0] mcnt;
  logic [4:0] bcnt;
  logic [55:0] prod;
  logic [NUM_W-1:0] acc, rem, dsh;
  logic signed [PLANE_W-1:0] dn;
  logic [DEPTH_W-1:0] q;
  logic bad;
  logic [1:0] sel;
  logic signed [5:0] si, sj;
  logic signed [47:0] off;
  logic [2:0] fm1;
  logic last_sub, dpos, npos, load;
  logic [15:0] col_full, row_full;

  assign sel      = 2'(2'd2 - mcnt);
  assign si       = $signed({2'b0, i, 1'b0}) + 6'sd1 - $signed({2'b0, cfg.f});
  assign sj       = $signed({2'b0, j, 1'b0}) + 6'sd1 - $signed({2'b0, cfg.f});
  assign off      = cur.u * si + cur.v * sj;
  assign fm1      = 3'(cfg.f - 4'd1);
  assign last_sub = (i == fm1) && (j == fm1);
  assign dpos     = !dn[PLANE_W-1] && (dn != '0);
  assign npos     = !cur.nm[PLANE_W-1] && (cur.nm != '0);
  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign load     = (state == ST_OUT) && (!m_tvalid || m_tready);
  assign col_full = 16'(cur.c) * 16'(cfg.f) + 16'(i);
  assign row_full = 16'(cur.r) * 16'(cfg.f) + 16'(j);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: if (q_valid) state <= ST_MUL;
        ST_MUL:  if (mcnt == 2'd3) state <= ST_RAY;
        ST_RAY:  state <= ST_CHK;
        ST_CHK: begin
          if (!dpos || !npos || cur.d == '0 || acc >= {dn[PLANE_W-1:0], 32'b0}) begin
            state <= ST_OUT;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV:  if (bcnt == 5'd0) state <= ST_OUT;
        ST_OUT:  if (load) state <= last_sub ? ST_IDLE : ST_RAY;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur <= q_item;
        i <= 3'd0; j <= 3'd0;
        mcnt <= 2'd0;
        acc <= '0;
      end
      ST_MUL: begin
        // depth times plane term, 24-bit chunks from the top
        if (mcnt != 2'd0) acc <= (acc << 24) + NUM_W'(prod);
        if (mcnt != 2'd3) prod <= cur.d * cur.nm[sel*24 +: 24];
        mcnt <= mcnt + 2'd1;
      end
      ST_RAY: dn <= cur.nm + (off <<< 8);
      ST_CHK: begin
        bad <= !dpos;
        rem <= acc;
        dsh <= {1'b0, dn[PLANE_W-1:0], 31'b0};
        bcnt <= 5'd31;
        if (!dpos || !npos || cur.d == '0) q <= '0;
        else q <= '1;  // saturated unless the divider overwrites it
      end
      ST_DIV: begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          q <= {q[DEPTH_W-2:0], 1'b1};
        end else begin
          q <= {q[DEPTH_W-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        bcnt <= bcnt - 5'd1;
      end
      ST_OUT: begin
        if (load) begin
          m_tdata <= {2'b0, q, row_full[14:0], col_full[14:0]};
          m_tuser <= bad;
          m_tlast <= last_sub;
          if (i == fm1) begin
            i <= 3'd0;
            j <= j + 3'd1;
          end else begin
            i <= i + 3'd1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule
